// ===== src/mmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mmm_pkg;

    // request codes carried in s_tuser
    typedef enum logic [1:0] {
        FN_POST  = 2'd0,
        FN_RECV  = 2'd1,
        FN_QUERY = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PENDING = 3'd1,
        ST_BUSY    = 3'd2,
        ST_TYPE    = 3'd3,
        ST_TAG     = 3'd4,
        ST_COMM    = 3'd5,
        ST_COUNT   = 3'd6
    } status_t;

    // classified operations handed from front to back
    typedef enum logic [2:0] {
        OP_POST,
        OP_QUERY,
        OP_RECV_ONE,
        OP_RECV_ANY,
        OP_FIXED
    } op_t;

    localparam int RANK_W   = 3;
    localparam int TAG_W    = 16;
    localparam int TYPE_W   = 4;
    localparam int COMM_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int ADDR_W   = 32;
    localparam int S_DATA_W = 88;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 72;

    // contents of one mailbox slot
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [TYPE_W-1:0]  dtype;
        logic [COMM_W-1:0]  comm;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  addr;
    } slot_t;

    // one queued command
    typedef struct packed {
        op_t               op;
        status_t           fixed_status;
        logic [RANK_W-1:0] own;
        logic [RANK_W-1:0] peer;
        logic              any_tag;
        slot_t             msg;
    } cmd_t;

    // match one slot against a receive, first failing check wins
    function automatic status_t check_slot(input logic full, input slot_t slot,
                                           input cmd_t cmd,
                                           input logic [TAG_W-1:0] mask);
        status_t result;
        logic    tag_bad;
        tag_bad = cmd.any_tag ? ((slot.tag & mask) == '0) : (slot.tag != cmd.msg.tag);
        if (!full)
            result = ST_PENDING;
        else if (slot.dtype != cmd.msg.dtype)
            result = ST_TYPE;
        else if (tag_bad)
            result = ST_TAG;
        else if (slot.comm != cmd.msg.comm)
            result = ST_COMM;
        else if (slot.count != cmd.msg.count)
            result = ST_COUNT;
        else
            result = ST_OK;
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== src/mmm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/mmm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmm_front #(
    parameter int NUM_PROCS = 8
) (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mmm_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic [mmm_pkg::S_USER_W-1:0]  s_tuser,
    input  wire logic                          q_full,
    output logic                               push,
    output mmm_pkg::cmd_t                      cmd
);

    import mmm_pkg::*;

    func_t             func;
    logic [RANK_W-1:0] own_rank;
    logic [RANK_W-1:0] peer_rank;
    logic              any_source;
    logic              own_ok;
    logic              peer_ok;

    // word layout
    assign func       = func_t'(s_tuser);
    assign own_rank   = s_tdata[2:0];
    assign peer_rank  = s_tdata[5:3];
    assign any_source = s_tdata[6];

    assign own_ok  = int'(own_rank) < NUM_PROCS;
    assign peer_ok = int'(peer_rank) < NUM_PROCS;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // classify the request so the back end sees only valid slot accesses
    always_comb
    begin
        cmd.own          = own_rank;
        cmd.peer         = peer_rank;
        cmd.any_tag      = s_tdata[23];
        cmd.msg.tag      = s_tdata[22:7];
        cmd.msg.dtype    = s_tdata[27:24];
        cmd.msg.comm     = s_tdata[35:28];
        cmd.msg.count    = s_tdata[51:36];
        cmd.msg.addr     = s_tdata[83:52];
        cmd.op           = OP_FIXED;
        cmd.fixed_status = ST_OK;
        case (func)
            FN_POST:
            begin
                if (own_ok && peer_ok)
                    cmd.op = OP_POST;
                else
                    cmd.fixed_status = ST_BUSY;
            end
            FN_QUERY:
            begin
                if (own_ok && peer_ok)
                    cmd.op = OP_QUERY;
            end
            FN_RECV:
            begin
                cmd.fixed_status = ST_PENDING;
                if (own_ok && any_source)
                    cmd.op = OP_RECV_ANY;
                else if (own_ok && peer_ok)
                    cmd.op = OP_RECV_ONE;
            end
            default:
            begin
                cmd.op = OP_FIXED;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/mmm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mmm_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output mmm_pkg::cmd_t      head
);

    import mmm_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // two-entry command queue between front and back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                entry_reg[wr_ptr_reg] <= push_cmd;
                wr_ptr_reg            <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mmm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mmm_back #(
    parameter int NUM_PROCS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [mmm_pkg::TAG_W-1:0]     user_tag_mask,
    input  wire logic                          q_empty,
    input  wire mmm_pkg::cmd_t                 q_head,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mmm_pkg::M_DATA_W-1:0]       m_tdata
);

    import mmm_pkg::*;

    localparam int SLOTS  = NUM_PROCS * NUM_PROCS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SRC_W  = $clog2(NUM_PROCS);
    localparam logic [SLOT_W-1:0] N_SLOT   = SLOT_W'(NUM_PROCS);
    localparam logic [SRC_W-1:0]  LAST_SRC = SRC_W'(NUM_PROCS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [SLOTS-1:0]     full_reg;
    logic [SRC_W-1:0]     iss_src_reg;
    logic [SRC_W-1:0]     last_src_reg;
    logic                 iss_more_reg;
    logic                 chk_valid_reg;
    logic [SRC_W-1:0]     chk_src_reg;
    logic                 chk_full_reg;
    status_t              res_status_reg;
    logic [RANK_W-1:0]    res_src_reg;
    logic [TAG_W-1:0]     res_tag_reg;
    logic [ADDR_W-1:0]    res_addr_reg;
    logic [COUNT_W-1:0]   res_count_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic [SLOT_W-1:0]    pq_idx;
    logic [SLOT_W-1:0]    rd_idx;
    logic [SLOT_W-1:0]    chk_idx;
    slot_t                rd_data;
    status_t              chk_status;
    status_t              fin_status;
    logic                 finish;
    logic                 hit;
    logic                 ram_we;
    logic                 ram_re;
    logic                 out_free;

    function automatic logic [SLOT_W-1:0] slot_idx(input logic [SLOT_W-1:0] src,
                                                   input logic [SLOT_W-1:0] dst);
        return src * N_SLOT + dst;
    endfunction

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // slot addresses: post/query from the queue head, scan from the command
    assign pq_idx  = slot_idx(SLOT_W'(q_head.own), SLOT_W'(q_head.peer));
    assign rd_idx  = slot_idx(SLOT_W'(iss_src_reg), SLOT_W'(cmd_reg.own));
    assign chk_idx = slot_idx(SLOT_W'(chk_src_reg), SLOT_W'(cmd_reg.own));

    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign ram_we   = pop && (q_head.op == OP_POST) && !full_reg[pq_idx];
    assign out_free = !m_tvalid_reg || m_tready;

    assign chk_status = check_slot(chk_full_reg, rd_data, cmd_reg, user_tag_mask);

    // decide the end of a receive scan
    always_comb
    begin
        finish     = 1'b0;
        hit        = 1'b0;
        fin_status = ST_PENDING;
        if ((state_reg == S_SCAN) && chk_valid_reg)
        begin
            if (cmd_reg.op == OP_RECV_ONE)
            begin
                finish     = 1'b1;
                fin_status = chk_status;
                hit        = chk_status == ST_OK;
            end
            else if (chk_status == ST_OK)
            begin
                finish     = 1'b1;
                fin_status = ST_OK;
                hit        = 1'b1;
            end
            else if (!iss_more_reg)
            begin
                finish = 1'b1;
            end
        end
    end

    assign ram_re = (state_reg == S_SCAN) && iss_more_reg && !finish;

    mmm_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pq_idx),
        .wdata (q_head.msg),
        .re    (ram_re),
        .raddr (rd_idx),
        .rdata (rd_data)
    );

    // sequencer: take a command, run it, hand the result word to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            full_reg      <= '0;
            iss_more_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            // the done state reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                full_reg[pq_idx] <= 1'b1;
            end

            // read issue, one source a cycle
            chk_valid_reg <= ram_re;
            if (ram_re)
            begin
                chk_src_reg  <= iss_src_reg;
                chk_full_reg <= full_reg[rd_idx];
                if (iss_src_reg == last_src_reg)
                    iss_more_reg <= 1'b0;
                else
                    iss_src_reg <= iss_src_reg + 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        cmd_reg        <= q_head;
                        res_status_reg <= ST_OK;
                        res_src_reg    <= '0;
                        res_tag_reg    <= '0;
                        res_addr_reg   <= '0;
                        res_count_reg  <= '0;
                        state_reg      <= S_DONE;
                        case (q_head.op)
                            OP_POST:
                            begin
                                if (full_reg[pq_idx])
                                    res_status_reg <= ST_BUSY;
                            end
                            OP_QUERY:
                            begin
                                if (full_reg[pq_idx])
                                    res_status_reg <= ST_PENDING;
                            end
                            OP_RECV_ONE:
                            begin
                                iss_src_reg  <= SRC_W'(q_head.peer);
                                last_src_reg <= SRC_W'(q_head.peer);
                                iss_more_reg <= 1'b1;
                                state_reg    <= S_SCAN;
                            end
                            OP_RECV_ANY:
                            begin
                                iss_src_reg  <= '0;
                                last_src_reg <= LAST_SRC;
                                iss_more_reg <= 1'b1;
                                state_reg    <= S_SCAN;
                            end
                            default:
                            begin
                                res_status_reg <= q_head.fixed_status;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (finish)
                    begin
                        res_status_reg <= fin_status;
                        iss_more_reg   <= 1'b0;
                        if (hit)
                        begin
                            res_src_reg       <= RANK_W'(chk_src_reg);
                            res_tag_reg       <= rd_data.tag;
                            res_addr_reg      <= rd_data.addr;
                            res_count_reg     <= rd_data.count;
                            full_reg[chk_idx] <= 1'b0;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, res_count_reg, res_addr_reg, res_tag_reg,
                                         res_src_reg, res_status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a slot compare is only in flight during a scan
    a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == S_SCAN))
        else $error("slot compare outside a scan");

    // a post only writes a free slot, and marks it full
    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !full_reg[pq_idx])
        else $error("post overwrote a full slot");

    a_post_marks: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> full_reg[$past(pq_idx)])
        else $error("posted slot not marked full");

    // a new result word only comes out of the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word loaded outside done state");

endmodule

`default_nettype wire

// ===== src/mailbox_matrix_matcher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Mailbox matrix matcher: one message slot per ordered (sender, receiver) pair of
// NUM_PROCS processors. Requests come in on the s_ stream (post, receive, query),
// each giving exactly one result word on the m_ stream, in request order. A front
// end classifies each request into a two-entry queue; the back end runs one command
// at a time against full flags held in flip-flops and slot contents held in one
// RAM with a single registered read port. Post, query and rejected requests go
// from idle to done; a named receive reads its one slot in the scan state, an
// any-source receive one source slot per cycle, up to NUM_PROCS, to the first
// match. The output register lets a new request start while a result waits.
// user_tag_mask sits at APB address 0 and should be written only while idle.

module mailbox_matrix_matcher_top #(
    parameter int NUM_PROCS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // own_rank, peer_rank, any_source, msg_tag, any_tag, data_type,
    // communicator, element_count, buffer_address, zero pad
    input  wire logic [mmm_pkg::S_DATA_W-1:0]  s_tdata,
    // func
    input  wire logic [mmm_pkg::S_USER_W-1:0]  s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status, matched_source, matched_tag, message_address, message_count, zero pad
    output logic [mmm_pkg::M_DATA_W-1:0]       m_tdata,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import mmm_pkg::*;

    logic [TAG_W-1:0] user_tag_mask_reg;
    logic             push;
    cmd_t             push_cmd;
    logic             q_full;
    logic             q_empty;
    logic             pop;
    cmd_t             q_head;
    logic             cfg_wr;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {16'd0, user_tag_mask_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_tag_mask_reg <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            user_tag_mask_reg <= pwdata[TAG_W-1:0];
        end
    end

    mmm_front #(
        .NUM_PROCS (NUM_PROCS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    mmm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    mmm_back #(
        .NUM_PROCS (NUM_PROCS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .user_tag_mask (user_tag_mask_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule

`default_nettype wire
